// File: hw/rtl/imu_sti_pkg.sv
// Package for the IMU sample time interpolator.
// Holds the request, result and stored-sample types and the fixed constants.
// No dependencies.
package imu_sti_pkg;

    typedef struct packed {
        logic              req_type;
        logic [47:0]       stamp_us;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [47:0]        out_stamp_us;
        logic signed [31:0] out_accel_x;
        logic signed [31:0] out_accel_y;
        logic signed [31:0] out_accel_z;
        logic signed [31:0] out_rate_x;
        logic signed [31:0] out_rate_y;
        logic signed [31:0] out_rate_z;
        logic signed [15:0] out_quat_x;
        logic signed [15:0] out_quat_y;
        logic signed [15:0] out_quat_z;
        logic signed [15:0] out_quat_w;
    } res_t;

    typedef struct packed {
        logic [47:0]        stamp;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
    } sample_t;

    localparam logic [1:0] ST_STORED = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;
    localparam logic [1:0] ST_FAIL   = 2'd3;

    localparam logic [23:0]        MAX_GAP_RESET = 24'd200000;
    localparam logic signed [15:0] QUAT_ONE      = 16'sd16384;

    // divider: 64-bit dividend, 25-bit divisor, quotient known to fit 34 bits
    localparam int DIV_QBITS = 34;
    // square root: 50-bit radicand, 25-bit root
    localparam int SQRT_STEPS = 25;

endpackage

// File: hw/rtl/imu_sti_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module imu_sti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/imu_sti_front.sv
// Front end: accepts command transactions into a two-entry queue.
// Depends on imu_sti_pkg.
module imu_sti_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  imu_sti_pkg::req_t req,
    input  logic              pop,
    output logic              avail,
    output imu_sti_pkg::req_t cmd
);

    imu_sti_pkg::req_t entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        cnt_reg;
    logic              push;
    logic              take;

    assign busy  = (cnt_reg == 2'd2);
    assign avail = (cnt_reg != 2'd0);
    assign cmd   = entry_reg[rd_ptr_reg];
    assign push  = start && !busy;
    assign take  = pop && avail;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (take)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, take};
        end
    end

endmodule

// File: hw/rtl/imu_sti_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on imu_sti_pkg; caller guarantees the quotient fits DIV_QBITS bits.
module imu_sti_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] dividend,
    input  logic [24:0] divisor,
    output logic        done,
    output logic [imu_sti_pkg::DIV_QBITS-1:0] quot
);

    localparam int QB = imu_sti_pkg::DIV_QBITS;

    logic              run_reg;
    logic              done_reg;
    logic [5:0]        cnt_reg;
    logic [25:0]       rem_reg;
    logic [QB-1:0]     dvd_reg;
    logic [QB-1:0]     quot_reg;
    logic [24:0]       dsr_reg;
    logic [25:0]       trial;
    logic              fits;

    assign trial = {rem_reg[24:0], dvd_reg[QB-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg  <= dividend[QB+25:QB];
            dvd_reg  <= dividend[QB-1:0];
            dsr_reg  <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg  <= fits ? (trial - {1'b0, dsr_reg}) : trial;
            dvd_reg  <= {dvd_reg[QB-2:0], 1'b0};
            quot_reg <= {quot_reg[QB-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 6'(QB);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// File: hw/rtl/imu_sti_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on imu_sti_pkg.
module imu_sti_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [49:0] radicand,
    output logic        done,
    output logic [24:0] root
);

    logic        run_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [27:0] rem_reg;
    logic [24:0] root_reg;
    logic [49:0] src_reg;
    logic [27:0] remx;
    logic [27:0] trial;
    logic        fits;

    assign remx  = {rem_reg[25:0], src_reg[49:48]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign fits  = (remx >= trial);

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg  <= '0;
            root_reg <= '0;
            src_reg  <= radicand;
        end
        else if (run_reg)
        begin
            rem_reg  <= fits ? (remx - trial) : remx;
            root_reg <= {root_reg[23:0], fits};
            src_reg  <= {src_reg[47:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 5'(imu_sti_pkg::SQRT_STEPS);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: hw/rtl/imu_sti_back.sv
// Back end: sample store, bracket search, interpolation and quaternion normalisation.
// Depends on imu_sti_pkg, imu_sti_ram, imu_sti_div and imu_sti_sqrt.
module imu_sti_back #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              avail,
    output logic              pop,
    input  imu_sti_pkg::req_t cmd,
    input  logic [23:0]       max_gap,
    output logic              res_valid,
    output imu_sti_pkg::res_t res
);

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int QB = imu_sti_pkg::DIV_QBITS;

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_RD0, S_RD1, S_CHK, S_M0, S_M1, S_M2, S_DIV,
        S_SQ, S_SQA, S_SQC, S_SQRT, S_NDIV0, S_NDIV
    } state_t;

    state_t                  state_reg;
    logic [AW-1:0]           head_reg;
    logic [CW-1:0]           count_reg;
    logic [47:0]             target_reg;
    imu_sti_pkg::sample_t    e0_reg;
    imu_sti_pkg::sample_t    e1_reg;
    logic [3:0]              ch_reg;
    logic signed [57:0]      acc_reg;
    logic signed [57:0]      prod_reg;
    logic                    neg_reg;
    logic signed [16:0]      qraw_reg [4];
    logic [32:0]             sq_reg;
    logic [24:0]             norm_reg;
    logic [23:0]             wf_reg;
    logic [23:0]             wb_reg;
    logic [24:0]             d_reg;
    imu_sti_pkg::res_t       res_reg;
    logic                    res_valid_reg;

    logic [AW-1:0]           head1;
    logic [SW-1:0]           tail_sum;
    logic [AW-1:0]           waddr;
    logic                    ram_we;
    logic                    ram_re;
    logic [AW-1:0]           raddr;
    imu_sti_pkg::sample_t    wsample;
    imu_sti_pkg::sample_t    rsample;

    logic signed [32:0]      mul_a;
    logic signed [24:0]      mul_b;
    logic signed [57:0]      mul_p;
    logic signed [57:0]      num;
    logic [57:0]             num_mag;
    logic signed [16:0]      qsel;
    logic [16:0]             qmag;

    logic                    div_go;
    logic [63:0]             div_dividend;
    logic [24:0]             div_divisor;
    logic                    div_done;
    logic [QB-1:0]           div_quot;
    logic [QB-1:0]           qs;
    logic                    sqrt_done;
    logic [24:0]             sqrt_root;
    logic                    is_full;

    function automatic imu_sti_pkg::res_t status_only(input logic [1:0] s);
        imu_sti_pkg::res_t r;
        r        = '0;
        r.status = s;
        return r;
    endfunction

    function automatic logic signed [32:0] chan(input imu_sti_pkg::sample_t s,
                                                 input logic [3:0] c);
        logic signed [32:0] v;
        case (c)
            4'd0:    v = {s.ax[31], s.ax};
            4'd1:    v = {s.ay[31], s.ay};
            4'd2:    v = {s.az[31], s.az};
            4'd3:    v = {s.rx[31], s.rx};
            4'd4:    v = {s.ry[31], s.ry};
            4'd5:    v = {s.rz[31], s.rz};
            4'd6:    v = {{17{s.qx[15]}}, s.qx};
            4'd7:    v = {{17{s.qy[15]}}, s.qy};
            4'd8:    v = {{17{s.qz[15]}}, s.qz};
            default: v = {{17{s.qw[15]}}, s.qw};
        endcase
        return v;
    endfunction

    // ring indices
    assign head1    = (head_reg == AW'(FIFO_DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign tail_sum = SW'(head_reg) + SW'(count_reg);
    assign waddr    = (tail_sum >= SW'(FIFO_DEPTH)) ? AW'(tail_sum - SW'(FIFO_DEPTH))
                                                    : AW'(tail_sum);
    assign is_full  = (count_reg == CW'(FIFO_DEPTH));

    assign pop    = (state_reg == S_IDLE) && avail;
    assign ram_we = pop && !cmd.req_type && !is_full;
    assign ram_re = (state_reg == S_SRCH) || (state_reg == S_RD0);
    assign raddr  = (state_reg == S_RD0) ? head1 : head_reg;

    always_comb
    begin
        wsample.stamp = cmd.stamp_us;
        wsample.ax    = cmd.accel_x;
        wsample.ay    = cmd.accel_y;
        wsample.az    = cmd.accel_z;
        wsample.rx    = cmd.rate_x;
        wsample.ry    = cmd.rate_y;
        wsample.rz    = cmd.rate_z;
        wsample.qx    = cmd.quat_x;
        wsample.qy    = cmd.quat_y;
        wsample.qz    = cmd.quat_z;
        wsample.qw    = cmd.quat_w;
    end

    imu_sti_ram #(
        .WIDTH ($bits(imu_sti_pkg::sample_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wsample),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rsample)
    );

    // shared multiplier: weights in the lerp states, squares afterwards
    assign qsel = qraw_reg[ch_reg[1:0]];
    always_comb
    begin
        case (state_reg)
            S_M0:
            begin
                mul_a = chan(e0_reg, ch_reg);
                mul_b = {1'b0, wf_reg};
            end
            S_M1:
            begin
                mul_a = chan(e1_reg, ch_reg);
                mul_b = {1'b0, wb_reg};
            end
            default:
            begin
                mul_a = {{16{qsel[16]}}, qsel};
                mul_b = {{8{qsel[16]}}, qsel};
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign num     = acc_reg + prod_reg;
    assign num_mag = num[57] ? 58'(-num) : 58'(num);
    assign qmag    = qsel[16] ? 17'(-qsel) : 17'(qsel);

    always_comb
    begin
        if (state_reg == S_NDIV0)
        begin
            div_go       = 1'b1;
            div_dividend = {25'b0, qmag, 22'b0} + {40'b0, norm_reg[24:1]};
            div_divisor  = norm_reg;
        end
        else
        begin
            div_go       = (state_reg == S_M2);
            div_dividend = {6'b0, num_mag} + {40'b0, d_reg[24:1]};
            div_divisor  = d_reg;
        end
    end

    imu_sti_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot)
    );

    imu_sti_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (state_reg == S_SQC && sq_reg != '0),
        .radicand ({1'b0, sq_reg, 16'b0}),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign qs = neg_reg ? QB'(-div_quot) : div_quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            ch_reg        <= '0;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (avail)
                    begin
                        if (cmd.req_type)
                        begin
                            target_reg <= cmd.stamp_us;
                            state_reg  <= S_SRCH;
                        end
                        else if (is_full)
                        begin
                            res_reg       <= status_only(imu_sti_pkg::ST_FULL);
                            res_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            count_reg     <= count_reg + CW'(1);
                            res_reg       <= status_only(imu_sti_pkg::ST_STORED);
                            res_valid_reg <= 1'b1;
                        end
                    end
                end
                S_SRCH:
                begin
                    if (count_reg < CW'(2))
                    begin
                        res_reg       <= status_only(imu_sti_pkg::ST_FAIL);
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_RD0;
                    end
                end
                S_RD0:
                begin
                    e0_reg    <= rsample;
                    state_reg <= S_RD1;
                end
                S_RD1:
                begin
                    e1_reg    <= rsample;
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (e0_reg.stamp > target_reg)
                    begin
                        res_reg       <= status_only(imu_sti_pkg::ST_FAIL);
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else if (e1_reg.stamp < target_reg)
                    begin
                        // drop the stale head and search again
                        head_reg  <= head1;
                        count_reg <= count_reg - CW'(1);
                        state_reg <= S_SRCH;
                    end
                    else if ((target_reg - e0_reg.stamp) > {24'b0, max_gap} ||
                             (e1_reg.stamp - target_reg) > {24'b0, max_gap})
                    begin
                        head_reg      <= head1;
                        count_reg     <= count_reg - CW'(1);
                        res_reg       <= status_only(imu_sti_pkg::ST_FAIL);
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else if (e0_reg.stamp == e1_reg.stamp)
                    begin
                        res_reg.status       <= imu_sti_pkg::ST_DONE;
                        res_reg.out_stamp_us <= target_reg;
                        res_reg.out_accel_x  <= e0_reg.ax;
                        res_reg.out_accel_y  <= e0_reg.ay;
                        res_reg.out_accel_z  <= e0_reg.az;
                        res_reg.out_rate_x   <= e0_reg.rx;
                        res_reg.out_rate_y   <= e0_reg.ry;
                        res_reg.out_rate_z   <= e0_reg.rz;
                        res_reg.out_quat_x   <= e0_reg.qx;
                        res_reg.out_quat_y   <= e0_reg.qy;
                        res_reg.out_quat_z   <= e0_reg.qz;
                        res_reg.out_quat_w   <= e0_reg.qw;
                        res_valid_reg        <= 1'b1;
                        state_reg            <= S_IDLE;
                    end
                    else
                    begin
                        wf_reg    <= 24'(e1_reg.stamp - target_reg);
                        wb_reg    <= 24'(target_reg - e0_reg.stamp);
                        d_reg     <= 25'(e1_reg.stamp - e0_reg.stamp);
                        ch_reg    <= '0;
                        state_reg <= S_M0;
                    end
                end
                S_M0:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_M1;
                end
                S_M1:
                begin
                    acc_reg   <= prod_reg;
                    prod_reg  <= mul_p;
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    neg_reg   <= num[57];
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        case (ch_reg)
                            4'd0:    res_reg.out_accel_x <= qs[31:0];
                            4'd1:    res_reg.out_accel_y <= qs[31:0];
                            4'd2:    res_reg.out_accel_z <= qs[31:0];
                            4'd3:    res_reg.out_rate_x  <= qs[31:0];
                            4'd4:    res_reg.out_rate_y  <= qs[31:0];
                            4'd5:    res_reg.out_rate_z  <= qs[31:0];
                            default: qraw_reg[2'(ch_reg - 4'd6)] <= qs[16:0];
                        endcase
                        if (ch_reg == 4'd9)
                        begin
                            ch_reg    <= '0;
                            sq_reg    <= '0;
                            state_reg <= S_SQ;
                        end
                        else
                        begin
                            ch_reg    <= ch_reg + 4'd1;
                            state_reg <= S_M0;
                        end
                    end
                end
                S_SQ:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_SQA;
                end
                S_SQA:
                begin
                    sq_reg <= sq_reg + prod_reg[32:0];
                    if (ch_reg == 4'd3)
                    begin
                        state_reg <= S_SQC;
                    end
                    else
                    begin
                        ch_reg    <= ch_reg + 4'd1;
                        state_reg <= S_SQ;
                    end
                end
                S_SQC:
                begin
                    if (sq_reg == '0)
                    begin
                        res_reg.status       <= imu_sti_pkg::ST_DONE;
                        res_reg.out_stamp_us <= target_reg;
                        res_reg.out_quat_x   <= '0;
                        res_reg.out_quat_y   <= '0;
                        res_reg.out_quat_z   <= '0;
                        res_reg.out_quat_w   <= imu_sti_pkg::QUAT_ONE;
                        res_valid_reg        <= 1'b1;
                        state_reg            <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        norm_reg  <= sqrt_root;
                        ch_reg    <= '0;
                        state_reg <= S_NDIV0;
                    end
                end
                S_NDIV0:
                begin
                    neg_reg   <= qsel[16];
                    state_reg <= S_NDIV;
                end
                S_NDIV:
                begin
                    if (div_done)
                    begin
                        case (ch_reg)
                            4'd0:    res_reg.out_quat_x <= qs[15:0];
                            4'd1:    res_reg.out_quat_y <= qs[15:0];
                            4'd2:    res_reg.out_quat_z <= qs[15:0];
                            default: res_reg.out_quat_w <= qs[15:0];
                        endcase
                        if (ch_reg == 4'd3)
                        begin
                            res_reg.status       <= imu_sti_pkg::ST_DONE;
                            res_reg.out_stamp_us <= target_reg;
                            res_valid_reg        <= 1'b1;
                            state_reg            <= S_IDLE;
                        end
                        else
                        begin
                            ch_reg    <= ch_reg + 4'd1;
                            state_reg <= S_NDIV0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: hw/rtl/imu_sample_time_interpolator_core.sv
// Top level of the IMU sample time interpolator; needs imu_sti_pkg, imu_sti_front, imu_sti_back.
// A push result is registered once the entry leaves the front queue; pushes run at one per
// cycle while no sync holds the back end. A sync tests brackets head by head, then forms two
// products and a divide per channel, squares the quaternion, takes its root and divides each
// quaternion part. Results are strobed for one cycle; the receiver cannot stall. Reset
// empties the command queue and sample store and loads the default gap limit.
module imu_sample_time_interpolator_core #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  imu_sti_pkg::req_t req,
    input  logic              cfg_we,
    input  logic [23:0]       cfg_wdata,
    output logic              res_valid,
    output imu_sti_pkg::res_t res
);

    logic              max_gap_reg_we;
    logic [23:0]       max_gap_reg;
    logic              pop;
    logic              avail;
    imu_sti_pkg::req_t cmd;

    assign max_gap_reg_we = cfg_we;

    // hold the gap limit; the user must write it only while the block is idle (not enforced here)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_gap_reg <= imu_sti_pkg::MAX_GAP_RESET;
        end
        else if (max_gap_reg_we)
        begin
            max_gap_reg <= cfg_wdata;
        end
    end

    // front: queue each transaction so the back end can run on its own
    imu_sti_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .pop   (pop),
        .avail (avail),
        .cmd   (cmd)
    );

    // back: store samples, search the bracket, interpolate and normalise
    imu_sti_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .avail     (avail),
        .pop       (pop),
        .cmd       (cmd),
        .max_gap   (max_gap_reg),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule

// File: tb/imu_sample_time_interpolator_core_tb.sv
// Self-checking testbench for the IMU sample time interpolator core.
// Depends on imu_sti_pkg and imu_sample_time_interpolator_core; holds its own
// predictor of the sample store, the bracket search and the interpolation.
module imu_sample_time_interpolator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 16;
    localparam int STALL_LIMIT = 50000;
    localparam logic [47:0] STAMP_MAX = 48'hFFFF_FFFF_FFFF;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    imu_sti_pkg::req_t req;
    logic              cfg_we;
    logic [23:0]       cfg_wdata;
    logic              res_valid;
    imu_sti_pkg::res_t res;

    imu_sample_time_interpolator_core #(.FIFO_DEPTH(STORE_DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .res_valid (res_valid),
        .res       (res)
    );

    // Shadow copy of the sample store and the gap register
    imu_sti_pkg::sample_t smp_store [STORE_DEPTH];
    int          smp_head;
    int          smp_count;
    logic [23:0] gap_limit;

    imu_sti_pkg::res_t due_results [$];
    int          mismatch_count;
    int          sent_count;
    int          checked_count;
    int          stall_cycles;
    logic [47:0] last_stamp;
    bit          idle_on;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Divide rounding to nearest, ties away from zero; den is positive.
    function automatic longint round_div(longint num, longint unsigned den);
        bit              neg;
        longint unsigned mag;
        longint unsigned quo;
        neg = num < 0;
        mag = neg ? longint'(0) - num : num;
        quo = (mag + den / 2) / den;
        return neg ? -longint'(quo) : longint'(quo);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Channel order: accel xyz, rate xyz, quaternion xyzw
    function automatic longint sample_channel(imu_sti_pkg::sample_t s, int i);
        case (i)
            0: return $signed(s.ax);
            1: return $signed(s.ay);
            2: return $signed(s.az);
            3: return $signed(s.rx);
            4: return $signed(s.ry);
            5: return $signed(s.rz);
            6: return $signed(s.qx);
            7: return $signed(s.qy);
            8: return $signed(s.qz);
            default: return $signed(s.qw);
        endcase
    endfunction

    function automatic void drop_head();
        smp_head  = (smp_head + 1) % STORE_DEPTH;
        smp_count = smp_count - 1;
    endfunction

    // Apply one transaction to the shadow store and return its result.
    function automatic imu_sti_pkg::res_t interp_predict(imu_sti_pkg::req_t r);
        imu_sti_pkg::res_t    o;
        imu_sti_pkg::sample_t s0;
        imu_sti_pkg::sample_t s1;
        logic [47:0]     tgt;
        logic [47:0]     t0;
        logic [47:0]     t1;
        longint unsigned d;
        longint unsigned wf;
        longint unsigned wb;
        longint unsigned sq;
        longint unsigned nrm;
        longint          v [10];
        bit              searching;
        int              i;
        o = '0;
        if (!r.req_type)
        begin
            if (smp_count >= STORE_DEPTH)
            begin
                o.status = imu_sti_pkg::ST_FULL;
                return o;
            end
            s0.stamp = r.stamp_us;
            s0.ax = r.accel_x;  s0.ay = r.accel_y;  s0.az = r.accel_z;
            s0.rx = r.rate_x;   s0.ry = r.rate_y;   s0.rz = r.rate_z;
            s0.qx = r.quat_x;   s0.qy = r.quat_y;   s0.qz = r.quat_z;
            s0.qw = r.quat_w;
            smp_store[(smp_head + smp_count) % STORE_DEPTH] = s0;
            smp_count = smp_count + 1;
            o.status = imu_sti_pkg::ST_STORED;
            return o;
        end

        tgt = r.stamp_us;
        o.status = imu_sti_pkg::ST_FAIL;
        searching = 1'b1;
        // Bracket search: drop heads until head and second straddle the target
        while (searching && smp_count >= 2)
        begin
            t0 = smp_store[smp_head].stamp;
            t1 = smp_store[(smp_head + 1) % STORE_DEPTH].stamp;
            if (t0 > tgt)
                return o;
            else if (t1 < tgt)
                drop_head();
            else if ((tgt - t0) > gap_limit || (t1 - tgt) > gap_limit)
            begin
                drop_head();
                return o;
            end
            else
                searching = 1'b0;
        end
        if (smp_count < 2)
            return o;

        s0 = smp_store[smp_head];
        s1 = smp_store[(smp_head + 1) % STORE_DEPTH];
        d  = s1.stamp - s0.stamp;
        wf = s1.stamp - tgt;
        wb = tgt - s0.stamp;
        o.status       = imu_sti_pkg::ST_DONE;
        o.out_stamp_us = tgt;
        for (i = 0; i < 10; i++)
        begin
            if (d == 0)
                v[i] = sample_channel(s0, i);
            else
                v[i] = round_div(sample_channel(s0, i) * longint'(wf)
                                 + sample_channel(s1, i) * longint'(wb), d);
        end
        // Equal neighbour times hand back the front quaternion untouched
        if (d != 0)
        begin
            sq = 0;
            for (i = 6; i < 10; i++)
                sq = sq + longint'(v[i] * v[i]);
            if (sq == 0)
            begin
                v[6] = 0; v[7] = 0; v[8] = 0; v[9] = imu_sti_pkg::QUAT_ONE;
            end
            else
            begin
                nrm = int_sqrt(sq << 16);
                for (i = 6; i < 10; i++)
                    v[i] = round_div(v[i] * 64'sd4194304, nrm);
            end
        end
        o.out_accel_x = v[0][31:0];
        o.out_accel_y = v[1][31:0];
        o.out_accel_z = v[2][31:0];
        o.out_rate_x  = v[3][31:0];
        o.out_rate_y  = v[4][31:0];
        o.out_rate_z  = v[5][31:0];
        o.out_quat_x  = v[6][15:0];
        o.out_quat_y  = v[7][15:0];
        o.out_quat_z  = v[8][15:0];
        o.out_quat_w  = v[9][15:0];
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Result checking: the receiver cannot stall, so sample every strobe
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic check_field(string nm, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", nm, got, want));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid)
        begin
            if (due_results.size() == 0)
                report_mismatch("result strobe with no transaction outstanding");
            else
            begin
                imu_sti_pkg::res_t want;
                want = due_results[0];
                due_results.delete(0);
                checked_count++;
                check_field("status",       res.status,       want.status);
                check_field("out_stamp_us", res.out_stamp_us, want.out_stamp_us);
                check_field("out_accel_x",  res.out_accel_x,  want.out_accel_x);
                check_field("out_accel_y",  res.out_accel_y,  want.out_accel_y);
                check_field("out_accel_z",  res.out_accel_z,  want.out_accel_z);
                check_field("out_rate_x",   res.out_rate_x,   want.out_rate_x);
                check_field("out_rate_y",   res.out_rate_y,   want.out_rate_y);
                check_field("out_rate_z",   res.out_rate_z,   want.out_rate_z);
                check_field("out_quat_x",   res.out_quat_x,   want.out_quat_x);
                check_field("out_quat_y",   res.out_quat_y,   want.out_quat_y);
                check_field("out_quat_z",   res.out_quat_z,   want.out_quat_z);
                check_field("out_quat_w",   res.out_quat_w,   want.out_quat_w);
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || res_valid)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog expired after %0d idle cycles", stall_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Hold start high until the block takes the transaction; start is left
    // high so a following transaction can go out back to back.
    task automatic send_item(imu_sti_pkg::req_t r);
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sent_count++;
        due_results.insert(due_results.size(), interp_predict(r));
    endtask

    task automatic maybe_idle();
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    function automatic imu_sti_pkg::req_t make_push(logic [47:0] st);
        imu_sti_pkg::req_t r;
        r.req_type = 1'b0;
        r.stamp_us = st;
        r.accel_x = $urandom; r.accel_y = $urandom; r.accel_z = $urandom;
        r.rate_x  = $urandom; r.rate_y  = $urandom; r.rate_z  = $urandom;
        r.quat_x  = 16'($urandom); r.quat_y = 16'($urandom); r.quat_z = 16'($urandom);
        r.quat_w  = 16'($urandom);
        return r;
    endfunction

    task automatic push_sample(logic [47:0] st);
        if (st > last_stamp)
            last_stamp = st;
        send_item(make_push(st));
    endtask

    // Payload fields of a sync are ignored, so fill them with noise
    task automatic request_sync(logic [47:0] tgt);
        imu_sti_pkg::req_t r;
        r = make_push(tgt);
        r.req_type = 1'b1;
        send_item(r);
    endtask

    // Hold the sender until every outstanding result has arrived, then write
    task automatic set_gap(logic [23:0] v);
        start <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        gap_limit = v;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_sparse_store();
        imu_sti_pkg::req_t r;
        // Sync with nothing stored, then with only one sample
        request_sync(48'd100);
        r = make_push(48'd1000);
        r.accel_x = 32'sh7FFF_FFFF; r.accel_y = 32'sh7FFF_FFFF; r.accel_z = 32'sh7FFF_FFFF;
        r.rate_x  = 32'sh7FFF_FFFF; r.rate_y  = 32'sh7FFF_FFFF; r.rate_z  = 32'sh7FFF_FFFF;
        r.quat_x  = 16'sh7FFF; r.quat_y = 16'sh7FFF; r.quat_z = 16'sh7FFF; r.quat_w = 16'sh7FFF;
        last_stamp = 48'd1000;
        send_item(r);
        request_sync(48'd1000);
    endtask

    task automatic test_bracketing();
        imu_sti_pkg::req_t r;
        r = make_push(48'd1100);
        r.accel_x = 32'sh8000_0000; r.accel_y = 32'sh8000_0000; r.accel_z = 32'sh8000_0000;
        r.rate_x  = 32'sh8000_0000; r.rate_y  = 32'sh8000_0000; r.rate_z  = 32'sh8000_0000;
        r.quat_x  = 16'sh8000; r.quat_y = 16'sh8000; r.quat_z = 16'sh8000; r.quat_w = 16'sh8000;
        last_stamp = 48'd1100;
        send_item(r);
        request_sync(48'd1050);  // midway between the extremes
        request_sync(48'd900);   // head newer than target
        push_sample(48'd1200);
        request_sync(48'd1150);  // drops the oldest sample first
        request_sync(48'd1200);  // target on the second sample
    endtask

    task automatic test_gap_and_equal_times();
        imu_sti_pkg::req_t r;
        push_sample(48'd1300);
        push_sample(48'd1300);
        set_gap(24'd50);
        request_sync(48'd1300);  // head too far back: dropped, sync fails
        request_sync(48'd1300);  // equal neighbour times
        set_gap(24'd0);
        request_sync(48'd1300);
        set_gap(imu_sti_pkg::MAX_GAP_RESET);
        // Two zero quaternions interpolate to zero: identity expected
        r = make_push(48'd1400);
        r.quat_x = '0; r.quat_y = '0; r.quat_z = '0; r.quat_w = '0;
        send_item(r);
        r = make_push(48'd1500);
        r.quat_x = '0; r.quat_y = '0; r.quat_z = '0; r.quat_w = '0;
        last_stamp = 48'd1500;
        send_item(r);
        request_sync(48'd1450);
        request_sync(48'd1499);
    endtask

    task automatic test_full_store();
        while (smp_count < STORE_DEPTH)
            push_sample(last_stamp + 48'd10);
        push_sample(last_stamp + 48'd10);  // dropped: store full
        request_sync(last_stamp - 48'd5);
    endtask

    task automatic test_random_phase(int n_items, logic [23:0] gap);
        longint unsigned lim;
        longint unsigned span;
        logic [47:0]     ta;
        logic [47:0]     tb;
        logic [47:0]     tgt;
        int              k;
        set_gap(gap);
        lim = (gap == 0) ? 2 : gap + gap / 4;
        for (int n = 0; n < n_items; n++)
        begin
            if ($urandom_range(0, 99) < 55)
            begin
                if ($urandom_range(0, 9) != 0)
                    push_sample(last_stamp + $urandom_range(0, 32'(lim)));
                else  // out-of-order sample
                    push_sample(last_stamp - (last_stamp > lim ?
                                              $urandom_range(0, 32'(lim)) : 0));
            end
            else if (smp_count >= 2 && $urandom_range(0, 3) != 0)
            begin
                // Aim between two stored neighbours
                k  = $urandom_range(0, smp_count - 2);
                ta = smp_store[(smp_head + k) % STORE_DEPTH].stamp;
                tb = smp_store[(smp_head + k + 1) % STORE_DEPTH].stamp;
                span = (tb > ta) ? tb - ta : 0;
                if (span > 64'h7FFF_FFFF)
                    span = 64'h7FFF_FFFF;
                tgt = ta + $urandom_range(0, 32'(span));
                request_sync(tgt);
            end
            else
            begin
                tgt = (last_stamp > 3 * lim) ? 48'(last_stamp - 3 * lim) : 48'd0;
                request_sync(tgt + $urandom_range(0, 32'(4 * lim)));
            end
            maybe_idle();
        end
    endtask

    // Runs last: a head at the top of the stamp range blocks later targets
    task automatic test_stamp_ceiling();
        set_gap(24'hFF_FFFF);
        push_sample(STAMP_MAX - 48'd8);
        push_sample(STAMP_MAX);
        request_sync(STAMP_MAX - 48'd4);
        request_sync(STAMP_MAX);
        start <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        start          = 1'b0;
        req            = '0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        rst_n          = 1'b0;
        mismatch_count = 0;
        sent_count     = 0;
        checked_count  = 0;
        smp_head       = 0;
        smp_count      = 0;
        gap_limit      = imu_sti_pkg::MAX_GAP_RESET;
        last_stamp     = '0;
        idle_on        = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_sparse_store();
        test_bracketing();
        test_gap_and_equal_times();
        test_full_store();

        idle_on = 1'b1;
        test_random_phase(290, 24'hFF_FFFF);
        test_random_phase(290, 24'd0);
        // Jump the time base so the upper stamp bits move
        last_stamp = last_stamp + {16'($urandom_range(0, 16'hFFFF)), $urandom};
        test_random_phase(290, 24'($urandom_range(1, 24'hFF_FFFF)));
        idle_on = 1'b0;  // final stretch runs back to back
        test_random_phase(290, imu_sti_pkg::MAX_GAP_RESET);
        test_stamp_ceiling();

        while (due_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Sent %0d pushes and syncs, checked %0d results over gap settings", sent_count,
                 checked_count);
        $display("from zero to full scale, with store overflow and equal-time neighbours.");
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
